/* src/fplr_pkg.sv */
// Shared widths, opcodes and default parameters of the fixed-point line rasterizer.
`timescale 1ns / 1ps
package fplr_pkg;

  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int ALPHA_W = 8;
  localparam int INDEX_W = 17;
  localparam int MAJOR_W = COORD_W + 1;

  localparam int DEFAULT_SCREEN_WIDTH  = 320;
  localparam int DEFAULT_SCREEN_HEIGHT = 240;
  localparam int DEFAULT_FRACTION_BITS = 16;

  localparam logic [ALPHA_W-1:0] REPLACE_ALPHA = 8'd250;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

endpackage

/* src/fplr_div.sv */
// Iterative restoring divider, one quotient bit per cycle, for the line slope.
`timescale 1ns / 1ps
module fplr_div
  import fplr_pkg::*;
#(
  parameter int DIVIDEND_W = COORD_W + DEFAULT_FRACTION_BITS,
  parameter int DIVISOR_W  = COORD_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;
  logic [DIVISOR_W:0]   diff;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(DIVIDEND_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

/* src/fixed_point_line_rasterizer_top.sv */
// Top level of the fixed-point line rasterizer: setup sequencer, slope divider and pixel stepper.
//
//   Channel  Dir  Beat content
//   s_axis   in   tuser: operation; tdata: start_x, start_y, end_x, end_y, pen_color, pen_alpha
//   m_axis   out  tuser: visible, replace; tdata: pixel_x, pixel_y, pixel_index, out_color,
//                 out_alpha; tlast: last
//
// A step beat yields one pixel beat while a line is active.
// A start beat with a nonzero major delta runs the bit-serial slope divider;
// s_axis_tready is low meanwhile.
// Reset is synchronous; it clears the line state and the output valid.
// A pixel beat waits in the output register; a new beat is taken in the cycle it drains.
`timescale 1ns / 1ps
module fixed_point_line_rasterizer_top
  import fplr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEFAULT_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEFAULT_SCREEN_HEIGHT,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y,
  // [63:48] pen_color, [71:64] pen_alpha
  input  logic [71:0] s_axis_tdata,
  // [0] operation
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [40:24] pixel_index, [56:41] out_color,
  // [64:57] out_alpha, [71:65] zero
  output logic [71:0] m_axis_tdata,
  // [0] visible, [1] replace
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int DIVIDEND_W = COORD_W + FRACTION_BITS;
  localparam int CW         = 32 - FRACTION_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t state;

  logic                 drawing;
  logic                 y_is_major;
  logic                 counting_up;
  logic [MAJOR_W-1:0]   major_pos;
  logic [MAJOR_W-1:0]   major_end;
  logic [31:0]          minor_acc;
  logic [31:0]          slope_step;
  logic [COLOR_W-1:0]   held_color;
  logic [ALPHA_W-1:0]   held_alpha;
  logic                 slope_neg;

  logic [COORD_W-1:0]   start_x;
  logic [COORD_W-1:0]   start_y;
  logic [COORD_W-1:0]   end_x;
  logic [COORD_W-1:0]   end_y;
  logic [COLOR_W-1:0]   pen_color;
  logic [ALPHA_W-1:0]   pen_alpha;
  op_t                  operation;
  logic                 accept;

  logic [MAJOR_W-1:0]   dx;
  logic [MAJOR_W-1:0]   dy;
  logic [MAJOR_W-1:0]   dx_abs;
  logic [MAJOR_W-1:0]   dy_abs;
  logic                 pick_y;
  logic [MAJOR_W-1:0]   major_d;
  logic [MAJOR_W-1:0]   minor_d;
  logic [COORD_W-1:0]   major_start;
  logic [COORD_W-1:0]   minor_start;
  logic [COORD_W-1:0]   major_mag;
  logic [COORD_W-1:0]   minor_mag;
  logic [31:0]          acc_init;

  logic                 div_start;
  logic                 div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [31:0]          quo_ext;

  logic [CW-1:0]        minor_coord;
  logic [CW-1:0]        major_coord;
  logic [CW-1:0]        x_full;
  logic [CW-1:0]        y_full;
  logic                 vis;
  logic                 fin;
  logic [21:0]          idx_full;

  assign start_x   = s_axis_tdata[11:0];
  assign start_y   = s_axis_tdata[23:12];
  assign end_x     = s_axis_tdata[35:24];
  assign end_y     = s_axis_tdata[47:36];
  assign pen_color = s_axis_tdata[63:48];
  assign pen_alpha = s_axis_tdata[71:64];
  assign operation = op_t'(s_axis_tuser[0]);

  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign dx     = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
  assign dy     = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
  assign dx_abs = dx[MAJOR_W-1] ? -dx : dx;
  assign dy_abs = dy[MAJOR_W-1] ? -dy : dy;
  assign pick_y = dy_abs[COORD_W-1:0] > dx_abs[COORD_W-1:0];

  assign major_d     = pick_y ? dy : dx;
  assign minor_d     = pick_y ? dx : dy;
  assign major_start = pick_y ? start_y : start_x;
  assign minor_start = pick_y ? start_x : start_y;
  assign major_mag   = pick_y ? dy_abs[COORD_W-1:0] : dx_abs[COORD_W-1:0];
  assign minor_mag   = pick_y ? dx_abs[COORD_W-1:0] : dy_abs[COORD_W-1:0];
  assign acc_init    = (32'd1 << (FRACTION_BITS - 1)) +
                       ({{(32 - COORD_W){minor_start[COORD_W-1]}}, minor_start}
                        << FRACTION_BITS);

  assign div_start = accept && (operation == OP_START) && (major_mag != '0);
  assign quo_ext   = {{(32 - DIVIDEND_W){1'b0}}, div_quo};

  fplr_div #(
    .DIVIDEND_W (DIVIDEND_W),
    .DIVISOR_W  (COORD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({minor_mag, {FRACTION_BITS{1'b0}}}),
    .divisor  (major_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign minor_coord = minor_acc[31:FRACTION_BITS];
  assign major_coord = {{(CW - MAJOR_W){major_pos[MAJOR_W-1]}}, major_pos};
  assign x_full      = y_is_major ? minor_coord : major_coord;
  assign y_full      = y_is_major ? major_coord : minor_coord;
  assign vis = (held_alpha != '0) &&
               !x_full[CW-1] && (x_full < CW'(SCREEN_WIDTH)) &&
               !y_full[CW-1] && (y_full < CW'(SCREEN_HEIGHT));
  assign fin = major_pos == major_end;
  assign idx_full = {11'd0, y_full[10:0]} * {11'd0, 11'(SCREEN_WIDTH)} +
                    {11'd0, x_full[10:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      drawing       <= 1'b0;
      y_is_major    <= 1'b0;
      counting_up   <= 1'b0;
      major_pos     <= '0;
      major_end     <= '0;
      minor_acc     <= '0;
      slope_step    <= '0;
      held_color    <= '0;
      held_alpha    <= '0;
      slope_neg     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept && (operation == OP_STEP) && drawing) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (operation == OP_START)) begin
            drawing     <= 1'b1;
            y_is_major  <= pick_y;
            counting_up <= !major_d[MAJOR_W-1] && (major_d != '0);
            major_pos   <= {major_start[COORD_W-1], major_start};
            major_end   <= {major_start[COORD_W-1], major_start} + major_d;
            minor_acc   <= acc_init;
            held_color  <= pen_color;
            held_alpha  <= pen_alpha;
            slope_neg   <= minor_d[MAJOR_W-1] ^ major_d[MAJOR_W-1];
            slope_step  <= '0;
            if (major_mag != '0) begin
              state <= ST_DIV;
            end
          end else if (accept && drawing) begin
            if (fin) begin
              drawing <= 1'b0;
            end else if (counting_up) begin
              major_pos <= major_pos + 1'b1;
              minor_acc <= minor_acc + slope_step;
            end else begin
              major_pos <= major_pos - 1'b1;
              minor_acc <= minor_acc - slope_step;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            slope_step <= slope_neg ? -quo_ext : quo_ext;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_STEP) && drawing) begin
      m_axis_tdata <= {7'd0, held_alpha, held_color,
                       vis ? idx_full[INDEX_W-1:0] : {INDEX_W{1'b0}},
                       y_full[COORD_W-1:0], x_full[COORD_W-1:0]};
      m_axis_tuser <= {held_alpha > REPLACE_ALPHA, vis};
      m_axis_tlast <= fin;
    end
  end

endmodule

/* bench/fixed_point_line_rasterizer_top_test.sv */
// Self-checking testbench for the line rasterizer: predicts every pixel beat and checks the output stream.
`timescale 1ns / 1ps
module fixed_point_line_rasterizer_top_test;
  import fplr_pkg::*;

  localparam int SCREEN_W     = DEFAULT_SCREEN_WIDTH;
  localparam int SCREEN_H     = DEFAULT_SCREEN_HEIGHT;
  localparam int FRAC         = DEFAULT_FRACTION_BITS;
  localparam int ITEM_TARGET  = 1250;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * (14 + FRAC);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] index;
    logic               visible;
    logic               replace;
    logic [COLOR_W-1:0] color;
    logic [ALPHA_W-1:0] alpha;
    logic               last;
  } pixel_t;

  class line_pixel_board;
    bit                 drawing;
    bit                 y_major;
    bit                 counting_up;
    int                 major_pos;
    int                 major_end;
    bit [31:0]          minor_acc;
    bit [31:0]          slope;
    logic [COLOR_W-1:0] held_color;
    logic [ALPHA_W-1:0] held_alpha;
    pixel_t             pending_pixels[$];
    int                 errors;
    int                 checked;

    function int pending();
      return pending_pixels.size();
    endfunction

    // Returns 1 when the beat does something: a start, or a step while a line is active.
    function bit note_beat(op_t op, logic [71:0] d);
      logic signed [COORD_W-1:0] sx, sy, ex, ey;
      int     dmaj, dmin, maj_start, min_start, minor, px, py;
      longint q;
      pixel_t p;
      if (op == OP_START) begin
        sx = d[11:0];
        sy = d[23:12];
        ex = d[35:24];
        ey = d[47:36];
        dmaj = int'(ex) - int'(sx);
        dmin = int'(ey) - int'(sy);
        maj_start = sx;
        min_start = sy;
        y_major = 1'b0;
        if ((dmin < 0 ? -dmin : dmin) > (dmaj < 0 ? -dmaj : dmaj)) begin
          y_major = 1'b1;
          dmaj = int'(ey) - int'(sy);
          dmin = int'(ex) - int'(sx);
          maj_start = sy;
          min_start = sx;
        end
        q = 0;
        if (dmaj != 0) q = (longint'(dmin) * (64'sd1 <<< FRAC)) / longint'(dmaj);
        slope = q[31:0];
        counting_up = dmaj > 0;
        major_pos = maj_start;
        major_end = maj_start + dmaj;
        minor_acc = (32'd1 << (FRAC - 1)) + (32'(min_start) << FRAC);
        held_color = d[63:48];
        held_alpha = d[71:64];
        drawing = 1'b1;
        return 1'b1;
      end
      if (!drawing) return 1'b0;
      minor = $signed(minor_acc) >>> FRAC;
      px = y_major ? minor : major_pos;
      py = y_major ? major_pos : minor;
      p.x = px[COORD_W-1:0];
      p.y = py[COORD_W-1:0];
      p.visible = held_alpha != 0 && px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H;
      p.index = p.visible ? INDEX_W'(py * SCREEN_W + px) : '0;
      p.replace = held_alpha > REPLACE_ALPHA;
      p.color = held_color;
      p.alpha = held_alpha;
      p.last = major_pos == major_end;
      pending_pixels.push_back(p);
      if (p.last) begin
        drawing = 1'b0;
      end else if (counting_up) begin
        major_pos++;
        minor_acc += slope;
      end else begin
        major_pos--;
        minor_acc -= slope;
      end
      return 1'b1;
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $error("pixel %0d: %s expected 0x%0h, got 0x%0h", checked, field, exp_v, act_v);
      end
    endfunction

    function void check_pixel(logic [71:0] d, logic [1:0] u, logic l);
      pixel_t p;
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("pixel beat with no pixel expected: data 0x%0h", d);
        return;
      end
      p = pending_pixels.pop_front();
      compare("pixel_x", p.x, d[11:0]);
      compare("pixel_y", p.y, d[23:12]);
      compare("pixel_index", p.index, d[40:24]);
      compare("out_color", p.color, d[56:41]);
      compare("out_alpha", p.alpha, d[64:57]);
      compare("visible", p.visible, u[0]);
      compare("replace", p.replace, u[1]);
      compare("last", p.last, l);
      checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  line_pixel_board board = new();
  int send_idle_pct = 38;
  int recv_idle_pct = 57;
  int items_done;
  int lines_started;
  int step_beats;
  int hold_left;
  bit hold_req;
  bit hold_done;
  int quiet_cycles;

  fixed_point_line_rasterizer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_pixel(m_tdata, m_tuser, m_tlast);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return REPLACE_ALPHA;
      2: return REPLACE_ALPHA + 8'd1;
      3: return 8'd255;
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(op_t op, logic [71:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (board.note_beat(op, d)) items_done++;
    if (op == OP_START) lines_started++;
    else step_beats++;
  endtask

  task automatic send_steps(int n);
    repeat (n) send_beat(OP_STEP, 72'({$urandom, $urandom, $urandom}));
  endtask

  // A negative step count walks the whole line.
  task automatic draw_line(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] color,
                           logic [ALPHA_W-1:0] alpha, int steps);
    int dx, dy;
    dx = ex > sx ? ex - sx : sx - ex;
    dy = ey > sy ? ey - sy : sy - ey;
    send_beat(OP_START, {alpha, color, 12'(ey), 12'(ex), 12'(sy), 12'(sx)});
    send_steps(steps < 0 ? (dx > dy ? dx : dy) + 1 : steps);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sx, sy, phase;
    phase = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_steps(1);
    draw_line(5, 7, 5, 7, 16'hFFFF, 8'd255, -1);
    send_steps(1);
    draw_line(0, 0, 2, 2, 16'h1234, REPLACE_ALPHA + 8'd1, -1);
    draw_line(-3, 1, -2, -2, 16'hA5A5, REPLACE_ALPHA, -1);
    draw_line(318, 238, 321, 239, 16'h5A5A, 8'd0, -1);
    draw_line(-2048, 2047, 2047, -2048, 16'h0000, 8'd1, 2);
    draw_line(2047, -2048, -2048, 2047, 16'hFFFF, 8'd255, 2);
    draw_line(0, 239, 0, 239, 16'h8001, 8'd128, -1);
    wait_drained();

    while (items_done < ITEM_TARGET) begin
      if (phase == 0 && items_done >= ITEM_TARGET / 3) begin
        wait_drained();
        phase = 1;
        send_idle_pct = 57;
        recv_idle_pct = 38;
      end else if (phase == 1 && items_done >= 2 * ITEM_TARGET / 3) begin
        wait_drained();
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:69]: begin
          sx = rand_between(-20, SCREEN_W + 20);
          sy = rand_between(-20, SCREEN_H + 20);
          draw_line(sx, sy, sx + rand_between(-24, 24), sy + rand_between(-24, 24),
                    COLOR_W'($urandom), pick_alpha(), -1);
        end
        [70:84]: begin
          draw_line(rand_between(-2048, 2047), rand_between(-2048, 2047),
                    rand_between(-2048, 2047), rand_between(-2048, 2047),
                    COLOR_W'($urandom), ALPHA_W'($urandom), rand_between(0, 6));
        end
        [85:94]: send_steps(rand_between(1, 4));
        default: begin
          sx = rand_between(0, SCREEN_W - 1);
          sy = rand_between(0, SCREEN_H - 1);
          draw_line(sx, sy, sx + rand_between(-300, 300), sy + rand_between(-300, 300),
                    COLOR_W'($urandom), pick_alpha(), -1);
        end
      endcase
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d lines and %0d step beats, %0d pixels checked,", lines_started,
             step_beats, board.checked);
    $display("under sender stalls, receiver stalls, a long output hold-off and full rate.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
